[design/edfr_pkg.sv]
`timescale 1ns / 1ps

package edfr_pkg;

	localparam int NUM_TASKS_DEF     = 8;
	localparam int DEADLINE_BITS_DEF = 32;

	// Field widths of the request and response channels.
	localparam int ACTION_W   = 2;
	localparam int TASK_ID_W  = 3;
	localparam int DEADLINE_W = 32;
	localparam int RANK_W     = 3;
	localparam int PRIO_W     = 6;

	localparam logic [PRIO_W-1:0] PRIO_MAX      = 6'd63;
	localparam logic [PRIO_W-1:0] BASE_PRIO_RST = 6'd1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_EVAL   = 2'd2
	} edfr_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} edfr_state_t;

	typedef struct packed {
		logic step;
		logic first;
		logic eligible;
	} edfr_scan_ctrl_t;

endpackage

[design/edfr_if.sv]
`timescale 1ns / 1ps

interface edfr_req_if;
	logic                            valid;
	logic                            ready;
	logic [edfr_pkg::ACTION_W-1:0]   action;
	logic [edfr_pkg::TASK_ID_W-1:0]  task_id;
	logic [edfr_pkg::DEADLINE_W-1:0] deadline;

	modport source (output valid, action, task_id, deadline, input ready);
	modport sink (input valid, action, task_id, deadline, output ready);
endinterface

interface edfr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [edfr_pkg::RANK_W-1:0]    rank;
	logic [edfr_pkg::TASK_ID_W-1:0] ranked_task;
	logic                           task_present;
	logic [edfr_pkg::PRIO_W-1:0]    new_priority;
	logic                           priority_changed;
	logic [edfr_pkg::TASK_ID_W-1:0] leader_task;
	logic                           leader_valid;
	logic                           preempted;
	logic                           last;

	modport source (output valid, rank, ranked_task, task_present, new_priority,
		priority_changed, leader_task, leader_valid, preempted, last, input ready);
	modport sink (input valid, rank, ranked_task, task_present, new_priority,
		priority_changed, leader_task, leader_valid, preempted, last, output ready);
endinterface

[design/edfr_min_unit.sv]
`timescale 1ns / 1ps

module edfr_min_unit #(
	parameter int DW = 32,
	parameter int TW = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  edfr_pkg::edfr_scan_ctrl_t ctrl,
	input  logic [DW-1:0]             cand_dl,
	input  logic [TW-1:0]             cand_idx,
	output logic [TW-1:0]             best_idx
);
	import edfr_pkg::*;

	logic [DW-1:0] best_dl_q;
	logic [TW-1:0] best_idx_q;
	logic          found_q;
	logic          take;

	// Candidates arrive in ascending index order, so a strict compare keeps
	// the lower index on equal deadlines.
	assign take = ctrl.step && ctrl.eligible &&
		(ctrl.first || !found_q || (cand_dl < best_dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.step) begin
			found_q <= take || (found_q && !ctrl.first);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_dl_q  <= cand_dl;
			best_idx_q <= cand_idx;
		end
	end

	assign best_idx = best_idx_q;

endmodule

[design/edf_priority_ranker.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Carries
// req       in   valid/ready    action, task_id, deadline
// rsp       out  valid/ready    one ranked task per response, last on the final rank
// cfg       in   cfg_we         base_priority in cfg_data
//
// Write and remove requests update the table as they are accepted. An evaluate request
// runs a selection sort through one shared deadline comparator: for each rank, a scan
// over all NUM_TASKS slots, then an issue step that emits that rank's response.
// req.ready is low for the whole evaluation; a stalled rsp holds the issue step.
// arst_n clears all task state and sets base_priority to 1.

module edf_priority_ranker #(
	parameter int NUM_TASKS     = edfr_pkg::NUM_TASKS_DEF,
	parameter int DEADLINE_BITS = edfr_pkg::DEADLINE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [edfr_pkg::PRIO_W-1:0] cfg_data,
	edfr_req_if.sink                    req,
	edfr_rsp_if.source                  rsp
);
	import edfr_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int DW = (DEADLINE_BITS < DEADLINE_W) ? DEADLINE_BITS : DEADLINE_W;
	localparam int SW = PRIO_W + 1;
	localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TASKS - 1);

	edfr_state_t state_q, state_d;

	logic [PRIO_W-1:0]    base_q;
	logic [DW-1:0]        dl_q [NUM_TASKS];
	logic [PRIO_W-1:0]    prio_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] present_q;
	logic [NUM_TASKS-1:0] used_q;
	logic [TW-1:0]        scan_q;
	logic [TW-1:0]        rank_q;
	logic [TW-1:0]        leader_q;
	logic                 leader_ok_q;
	logic [TW-1:0]        prev_leader_q;
	logic                 prev_leader_ok_q;
	logic                 any_chg_q;

	logic                 out_valid_q;
	logic [RANK_W-1:0]    out_rank_q;
	logic [TASK_ID_W-1:0] out_task_q;
	logic                 out_present_q;
	logic [PRIO_W-1:0]    out_prio_q;
	logic                 out_chg_q;
	logic [TASK_ID_W-1:0] out_leader_q;
	logic                 out_leader_ok_q;
	logic                 out_preempt_q;
	logic                 out_last_q;

	edfr_scan_ctrl_t scan_ctrl;
	logic            req_fire;
	logic            emit_fire;
	logic            req_ready;
	logic [TW-1:0]   tid;
	logic            tid_ok;
	logic [TW-1:0]   best_idx;
	logic [SW-1:0]   prio_sum;
	logic [PRIO_W-1:0] prio_new;
	logic            best_present;
	logic            chg;
	logic            last_rank;
	logic [TW-1:0]   leader_now;
	logic            leader_ok_now;
	logic            preempt_now;

	assign req_fire = req.valid && req_ready;
	assign req.ready = req_ready;
	assign tid = TW'(req.task_id);
	assign tid_ok = int'(req.task_id) < NUM_TASKS;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && (req.action == ACT_EVAL)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == LAST_IDX) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = last_rank ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		emit_fire = 1'b0;
		scan_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_SCAN: begin
				scan_ctrl.step     = 1'b1;
				scan_ctrl.first    = (scan_q == '0);
				scan_ctrl.eligible = !used_q[scan_q];
			end
			ST_EMIT: begin
				emit_fire = !out_valid_q || rsp.ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	edfr_min_unit #(
		.DW(DW),
		.TW(TW)
	) u_min (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (scan_ctrl),
		.cand_dl (dl_q[scan_q]),
		.cand_idx(scan_q),
		.best_idx(best_idx)
	);

	// Priority for this rank is base + NUM_TASKS - 1 - rank, saturated.
	assign prio_sum = SW'(base_q) + SW'(NUM_TASKS - 1) - SW'(rank_q);
	assign prio_new = (prio_sum > SW'(PRIO_MAX)) ? PRIO_MAX : prio_sum[PRIO_W-1:0];
	assign best_present = present_q[best_idx];
	assign chg = best_present && (prio_q[best_idx] != prio_new);
	assign last_rank = (rank_q == LAST_IDX);
	assign leader_now = (rank_q == '0) ? (best_present ? best_idx : '0) : leader_q;
	assign leader_ok_now = (rank_q == '0) ? best_present : leader_ok_q;
	assign preempt_now = last_rank && (any_chg_q || chg) && leader_ok_now &&
		prev_leader_ok_q && (leader_now != prev_leader_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_PRIO_RST;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				dl_q[i]   <= '0;
				prio_q[i] <= '0;
			end
			present_q <= '0;
		end else begin
			if (req_fire && tid_ok) begin
				case (edfr_action_t'(req.action))
					ACT_WRITE: begin
						dl_q[tid]      <= DW'(req.deadline);
						present_q[tid] <= 1'b1;
					end
					ACT_REMOVE: begin
						present_q[tid] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			// An absent task loses its stored priority when it is ranked.
			if (emit_fire) begin
				prio_q[best_idx] <= best_present ? prio_new : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q           <= '0;
			scan_q           <= '0;
			rank_q           <= '0;
			leader_q         <= '0;
			leader_ok_q      <= 1'b0;
			prev_leader_q    <= '0;
			prev_leader_ok_q <= 1'b0;
			any_chg_q        <= 1'b0;
		end else begin
			if (req_fire && (req.action == ACT_EVAL)) begin
				used_q    <= '0;
				scan_q    <= '0;
				rank_q    <= '0;
				any_chg_q <= 1'b0;
			end
			if (scan_ctrl.step) begin
				scan_q <= (scan_q == LAST_IDX) ? '0 : scan_q + 1'b1;
			end
			if (emit_fire) begin
				used_q[best_idx] <= 1'b1;
				rank_q           <= last_rank ? '0 : rank_q + 1'b1;
				any_chg_q        <= any_chg_q || chg;
				leader_q         <= leader_now;
				leader_ok_q      <= leader_ok_now;
				if (last_rank) begin
					prev_leader_q    <= leader_now;
					prev_leader_ok_q <= leader_ok_now;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_rank_q      <= RANK_W'(rank_q);
			out_task_q      <= TASK_ID_W'(best_idx);
			out_present_q   <= best_present;
			out_prio_q      <= prio_new;
			out_chg_q       <= chg;
			out_leader_q    <= TASK_ID_W'(leader_now);
			out_leader_ok_q <= leader_ok_now;
			out_preempt_q   <= preempt_now;
			out_last_q      <= last_rank;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.rank             = out_rank_q;
	assign rsp.ranked_task      = out_task_q;
	assign rsp.task_present     = out_present_q;
	assign rsp.new_priority     = out_prio_q;
	assign rsp.priority_changed = out_chg_q;
	assign rsp.leader_task      = out_leader_q;
	assign rsp.leader_valid     = out_leader_ok_q;
	assign rsp.preempted        = out_preempt_q;
	assign rsp.last             = out_last_q;

	// While scanning, at least one task is still waiting for a rank.
	a_unranked_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !(&used_q))
		else $error("scan started with every task already ranked");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && last_rank) |=> (state_q == ST_IDLE) && (&used_q))
		else $error("evaluation ended without ranking every task");

	a_preempt_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.preempted) |-> (rsp.last && rsp.leader_valid))
		else $error("preemption flagged off the final response");

	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && !last_rank) |=> !req.ready)
		else $error("request taken in the middle of an evaluation");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import edfr_pkg::*;

	localparam int NT = NUM_TASKS_DEF;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [RANK_W-1:0]    rank;
		logic [TASK_ID_W-1:0] task_no;
		logic                 present;
		logic [PRIO_W-1:0]    prio;
		logic                 changed;
		logic [TASK_ID_W-1:0] leader;
		logic                 leader_ok;
		logic                 preempt;
		logic                 last;
	} rank_result_t;

	// Shadow copy of the task table plus the queue of rank results still owed by the block.
	class edf_rank_scoreboard;
		logic [DEADLINE_W-1:0] deadlines [NT];
		bit                    present [NT];
		logic [PRIO_W-1:0]     prios [NT];
		logic [TASK_ID_W-1:0]  prev_leader;
		bit                    prev_leader_ok;
		logic [PRIO_W-1:0]     base;
		rank_result_t          pending_ranks [$];
		int errors;
		int n_writes;
		int n_removes;
		int n_evals;
		int n_ignored;
		int n_results;
		int n_preempts;
		int n_saturated;

		function new();
			for (int i = 0; i < NT; i++) begin
				deadlines[i] = '0;
				present[i] = 0;
				prios[i] = '0;
			end
			prev_leader = '0;
			prev_leader_ok = 0;
			base = BASE_PRIO_RST;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, what);
		endtask

		function void note_request(logic [ACTION_W-1:0] act, logic [TASK_ID_W-1:0] tid,
				logic [DEADLINE_W-1:0] dl);
			int order [NT];
			int r;
			int t;
			int p;
			bit chg;
			bit any_change;
			bit leader_ok;
			logic [TASK_ID_W-1:0] leader;
			rank_result_t res;
			case (act)
				ACT_WRITE: begin
					deadlines[tid] = dl;
					present[tid] = 1;
					n_writes++;
				end
				ACT_REMOVE: begin
					present[tid] = 0;
					n_removes++;
				end
				ACT_EVAL: begin
					n_evals++;
					// Ties on the deadline go to the lower task index, so ranks are a permutation.
					for (int i = 0; i < NT; i++) begin
						r = 0;
						for (int j = 0; j < NT; j++)
							if (deadlines[j] < deadlines[i] ||
									(deadlines[j] == deadlines[i] && j < i))
								r++;
						order[r] = i;
					end
					for (int i = 0; i < NT; i++)
						if (!present[i])
							prios[i] = '0;
					leader_ok = present[order[0]];
					leader = leader_ok ? TASK_ID_W'(order[0]) : '0;
					any_change = 0;
					for (int i = 0; i < NT; i++) begin
						t = order[i];
						p = int'(base) + NT - 1 - i;
						if (p > int'(PRIO_MAX)) begin
							p = int'(PRIO_MAX);
							n_saturated++;
						end
						chg = 0;
						if (present[t]) begin
							chg = (prios[t] != PRIO_W'(p));
							prios[t] = PRIO_W'(p);
							any_change |= chg;
						end
						res.rank = RANK_W'(i);
						res.task_no = TASK_ID_W'(t);
						res.present = present[t];
						res.prio = PRIO_W'(p);
						res.changed = chg;
						res.leader = leader;
						res.leader_ok = leader_ok;
						res.last = (i == NT - 1);
						res.preempt = (i == NT - 1) && any_change && leader_ok &&
							prev_leader_ok && (leader != prev_leader);
						if (res.preempt)
							n_preempts++;
						pending_ranks.push_back(res);
					end
					prev_leader = leader;
					prev_leader_ok = leader_ok;
				end
				default: n_ignored++;
			endcase
		endfunction

		task check_result(rank_result_t got);
			rank_result_t exp;
			if (pending_ranks.size() == 0) begin
				report_mismatch($sformatf("response with nothing pending (rank %0d task %0d)",
					got.rank, got.task_no));
				return;
			end
			exp = pending_ranks.pop_front();
			n_results++;
			if (got.rank !== exp.rank)
				report_mismatch($sformatf("rank %0d, want %0d", got.rank, exp.rank));
			if (got.task_no !== exp.task_no)
				report_mismatch($sformatf("rank %0d: ranked_task %0d, want %0d",
					exp.rank, got.task_no, exp.task_no));
			if (got.present !== exp.present)
				report_mismatch($sformatf("rank %0d: task_present %b, want %b",
					exp.rank, got.present, exp.present));
			if (got.prio !== exp.prio)
				report_mismatch($sformatf("rank %0d: new_priority %0d, want %0d",
					exp.rank, got.prio, exp.prio));
			if (got.changed !== exp.changed)
				report_mismatch($sformatf("rank %0d: priority_changed %b, want %b",
					exp.rank, got.changed, exp.changed));
			if (got.leader !== exp.leader)
				report_mismatch($sformatf("rank %0d: leader_task %0d, want %0d",
					exp.rank, got.leader, exp.leader));
			if (got.leader_ok !== exp.leader_ok)
				report_mismatch($sformatf("rank %0d: leader_valid %b, want %b",
					exp.rank, got.leader_ok, exp.leader_ok));
			if (got.preempt !== exp.preempt)
				report_mismatch($sformatf("rank %0d: preempted %b, want %b",
					exp.rank, got.preempt, exp.preempt));
			if (got.last !== exp.last)
				report_mismatch($sformatf("rank %0d: last %b, want %b",
					exp.rank, got.last, exp.last));
		endtask
	endclass

	logic              clk = 0;
	logic              arst_n;
	logic              cfg_we;
	logic [PRIO_W-1:0] cfg_data;
	bit                idle_on;
	bit                hold_armed;

	edfr_req_if req_ch ();
	edfr_rsp_if rsp_ch ();

	edf_priority_ranker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	edf_rank_scoreboard sb = new();

	always #1 clk = ~clk;

	always @(posedge clk) begin
		rank_result_t got;
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.action, req_ch.task_id, req_ch.deadline);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.rank = rsp_ch.rank;
			got.task_no = rsp_ch.ranked_task;
			got.present = rsp_ch.task_present;
			got.prio = rsp_ch.new_priority;
			got.changed = rsp_ch.priority_changed;
			got.leader = rsp_ch.leader_task;
			got.leader_ok = rsp_ch.leader_valid;
			got.preempt = rsp_ch.preempted;
			got.last = rsp_ch.last;
			sb.check_result(got);
		end
	end

	// Response side: random back-pressure, plus one long hold-off that fills the block up.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 0;
				hold_left--;
			end else if (idle_on) begin
				rsp_ch.ready = ($urandom_range(99) >= 33);
			end else begin
				rsp_ch.ready = 1;
			end
		end
	end

	initial begin
		#2000000;
		$display("Timeout with %0d responses still pending", sb.pending_ranks.size());
		$display("DONE: errors detected");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_req(logic [ACTION_W-1:0] act, logic [TASK_ID_W-1:0] tid,
			logic [DEADLINE_W-1:0] dl);
		while (idle_on && $urandom_range(99) < 33) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.valid = 1;
		req_ch.action = act;
		req_ch.task_id = tid;
		req_ch.deadline = dl;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid = 0;
		while (sb.pending_ranks.size() != 0)
			@(negedge clk);
		// A trailing write or removal finishes well within this wait.
		repeat (100) @(negedge clk);
	endtask

	task automatic set_base(logic [PRIO_W-1:0] value);
		drain();
		cfg_we = 1;
		cfg_data = value;
		sb.base = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic run_random(int count);
		int done;
		int pick;
		logic [ACTION_W-1:0]   act;
		logic [TASK_ID_W-1:0]  tid;
		logic [DEADLINE_W-1:0] dl;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(99);
			if (pick < 45)
				act = ACT_WRITE;
			else if (pick < 60)
				act = ACT_REMOVE;
			else if (pick < 95)
				act = ACT_EVAL;
			else
				act = ACT_UNUSED;
			tid = TASK_ID_W'($urandom_range(NT - 1));
			// Small and near-maximum deadlines make ties and wide-range compares common.
			case ($urandom_range(3))
				0: dl = $urandom_range(15);
				1: dl = 32'hFFFF_FFF0 | $urandom_range(15);
				default: dl = $urandom;
			endcase
			send_req(act, tid, dl);
			if (act != ACT_UNUSED)
				done++;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = '0;
		idle_on = 1;
		hold_armed = 0;
		req_ch.valid = 0;
		req_ch.action = ACT_WRITE;
		req_ch.task_id = '0;
		req_ch.deadline = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// All slots absent with equal deadlines: pure index order, no leader.
		send_req(ACT_EVAL, 3'd0, 32'd0);
		send_req(ACT_WRITE, 3'd7, 32'h0000_0000);
		send_req(ACT_WRITE, 3'd0, 32'hFFFF_FFFF);
		send_req(ACT_WRITE, 3'd3, 32'h8000_0000);
		send_req(ACT_WRITE, 3'd5, 32'h8000_0000);
		send_req(ACT_WRITE, 3'd1, 32'h5555_5555);
		send_req(ACT_WRITE, 3'd2, 32'hAAAA_AAAA);
		send_req(ACT_WRITE, 3'd4, 32'h7FFF_FFFF);
		send_req(ACT_EVAL, 3'd0, 32'd0);
		// Nothing moved, so no priority changes and no preemption.
		send_req(ACT_EVAL, 3'd7, 32'hFFFF_FFFF);
		// Task 6 ties task 7 on deadline and wins on index, taking over the lead.
		send_req(ACT_WRITE, 3'd6, 32'h0000_0000);
		send_req(ACT_EVAL, 3'd0, 32'd0);
		// The removed task keeps its stale deadline and still ranks first, so no leader.
		send_req(ACT_REMOVE, 3'd6, 32'd0);
		send_req(ACT_EVAL, 3'd0, 32'd0);
		send_req(ACT_REMOVE, 3'd6, 32'hFFFF_FFFF);
		send_req(ACT_UNUSED, 3'd5, 32'hDEAD_BEEF);
		send_req(ACT_WRITE, 3'd6, 32'hFFFF_FFFE);
		send_req(ACT_EVAL, 3'd0, 32'd0);

		run_random(50);

		set_base(6'd0);
		idle_on = 0;
		run_random(50);
		idle_on = 1;

		set_base(6'd56);
		run_random(25);
		hold_armed = 1;
		run_random(25);

		// Base above 56 pushes the top ranks past the 6-bit ceiling.
		set_base(6'd63);
		run_random(40);

		set_base(6'($urandom_range(56)));
		run_random(60);

		drain();
		$display("Covered %0d writes, %0d removals, %0d evaluations, %0d ignored requests",
			sb.n_writes, sb.n_removes, sb.n_evals, sb.n_ignored);
		$display("Checked %0d responses: %0d preemptions, %0d saturated priorities, %0d errors",
			sb.n_results, sb.n_preempts, sb.n_saturated, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[edf_priority_ranker.f]
design/edfr_pkg.sv
design/edfr_if.sv
design/edfr_min_unit.sv
design/edf_priority_ranker.sv
test/testbench.sv
